@@ sv/imm_pkg.sv @@
// ----------------------------------------------------------------------------
// imm_pkg
// types, sizes and helpers shared by the int16 matrix multiply block
// ----------------------------------------------------------------------------
package imm_pkg;

  localparam int MAX_DIM = 8;
  localparam int CELLS   = MAX_DIM * MAX_DIM;
  localparam int DIM_W   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int CNT_W   = $clog2(MAX_DIM + 1);
  localparam int ADDR_W  = $clog2(CELLS);

  // input item kinds
  localparam logic [1:0] KIND_LOAD_A = 2'd0;
  localparam logic [1:0] KIND_LOAD_B = 2'd1;
  localparam logic [1:0] KIND_LOAD_C = 2'd2;
  localparam logic [1:0] KIND_START  = 2'd3;

  // result modes
  localparam logic [1:0] MODE_SET = 2'd0;
  localparam logic [1:0] MODE_ADD = 2'd1;
  localparam logic [1:0] MODE_SUB = 2'd2;
  localparam logic [1:0] MODE_NEG = 2'd3;

  // configuration register indexes
  localparam logic [2:0] REG_OUT_ROWS    = 3'd0;
  localparam logic [2:0] REG_OUT_COLS    = 3'd1;
  localparam logic [2:0] REG_INNER_LEN   = 3'd2;
  localparam logic [2:0] REG_TRANSPOSE_A = 3'd3;
  localparam logic [2:0] REG_TRANSPOSE_B = 3'd4;
  localparam logic [2:0] REG_MODE        = 3'd5;

  typedef struct packed {
    logic [1:0]         kind;
    logic [2:0]         row;
    logic [2:0]         col;
    logic signed [15:0] value;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         out_row;
    logic [2:0]         out_col;
    logic signed [15:0] result;
    logic               last;
  } out_item_t;

  // tag that follows one multiply step down the pipeline
  typedef struct packed {
    logic             valid;
    logic             first;
    logic             last_k;
    logic             last_elem;
    logic [DIM_W-1:0] i;
    logic [DIM_W-1:0] j;
  } imm_tag_t;

  // write back of a finished element into store c
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [15:0]       data;
  } imm_wb_t;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [DIM_W-1:0] r,
                                                   input logic [DIM_W-1:0] c);
    return ADDR_W'(r) * ADDR_W'(MAX_DIM) + ADDR_W'(c);
  endfunction

  // saturate a size register to 1..MAX_DIM
  function automatic logic [CNT_W-1:0] clamp_dim(input logic [3:0] v);
    logic [CNT_W-1:0] r;
    if (v == 4'd0) r = CNT_W'(1);
    else if (int'(v) > MAX_DIM) r = CNT_W'(MAX_DIM);
    else r = CNT_W'(v);
    return r;
  endfunction

endpackage

@@ sv/imm_seq.sv @@
// ----------------------------------------------------------------------------
// imm_seq
// walks i, j, k over the product and issues store addresses, one step a cycle
// ----------------------------------------------------------------------------
module imm_seq (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      go,
  input  logic [3:0]                out_rows,
  input  logic [3:0]                out_cols,
  input  logic [3:0]                inner_len,
  input  logic                      transpose_a,
  input  logic                      transpose_b,
  output logic                      running,
  output logic [imm_pkg::ADDR_W-1:0] a_addr,
  output logic [imm_pkg::ADDR_W-1:0] b_addr,
  output logic [imm_pkg::ADDR_W-1:0] c_addr,
  output imm_pkg::imm_tag_t         tag
);
  import imm_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic             state;
  logic [DIM_W-1:0] i, j, k;
  logic [CNT_W-1:0] rows, cols, inner;
  logic             last_k, last_j, last_i;

  assign last_k = (CNT_W'(k) + CNT_W'(1)) == inner;
  assign last_j = (CNT_W'(j) + CNT_W'(1)) == cols;
  assign last_i = (CNT_W'(i) + CNT_W'(1)) == rows;

  assign running = (state == ST_RUN);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      i     <= '0;
      j     <= '0;
      k     <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (go) begin
            state <= ST_RUN;
            i     <= '0;
            j     <= '0;
            k     <= '0;
          end
        end
        ST_RUN: begin
          if (!last_k) begin
            k <= k + DIM_W'(1);
          end else begin
            k <= '0;
            if (!last_j) begin
              j <= j + DIM_W'(1);
            end else begin
              j <= '0;
              if (!last_i) i <= i + DIM_W'(1);
              else state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // sizes are latched once per product
  always_ff @(posedge clk) begin
    if (go && state == ST_IDLE) begin
      rows  <= clamp_dim(out_rows);
      cols  <= clamp_dim(out_cols);
      inner <= clamp_dim(inner_len);
    end
  end

  assign a_addr = transpose_a ? cell_addr(k, i) : cell_addr(i, k);
  assign b_addr = transpose_b ? cell_addr(j, k) : cell_addr(k, j);
  assign c_addr = cell_addr(i, j);

  always_comb begin
    tag.valid     = running;
    tag.first     = (k == '0);
    tag.last_k    = last_k;
    tag.last_elem = last_i && last_j;
    tag.i         = i;
    tag.j         = j;
  end

endmodule

@@ sv/imm_mac.sv @@
// ----------------------------------------------------------------------------
// imm_mac
// shared multiply-accumulate unit with the mode combine and result register
// ----------------------------------------------------------------------------
module imm_mac (
  input  logic                clk,
  input  logic                rst,
  input  imm_pkg::imm_tag_t   tag_in,
  input  logic signed [15:0]  a_val,
  input  logic signed [15:0]  b_val,
  input  logic [15:0]         c_cur,
  input  logic [1:0]          mode,
  output logic                active,
  output imm_pkg::imm_wb_t    wb,
  output logic                res_valid,
  output imm_pkg::out_item_t  res_item
);
  import imm_pkg::*;

  logic signed [31:0] prod_full;
  logic [15:0]        prod;
  logic [15:0]        cur;
  imm_tag_t           tag2;
  logic [15:0]        acc;
  logic [15:0]        acc_next;
  logic [15:0]        res;

  assign prod_full = a_val * b_val;

  // product stage
  always_ff @(posedge clk) begin
    if (rst) tag2.valid <= 1'b0;
    else     tag2.valid <= tag_in.valid;
    tag2.first     <= tag_in.first;
    tag2.last_k    <= tag_in.last_k;
    tag2.last_elem <= tag_in.last_elem;
    tag2.i         <= tag_in.i;
    tag2.j         <= tag_in.j;
    prod           <= prod_full[15:0];
    cur            <= c_cur;
  end

  assign active   = tag2.valid;
  assign acc_next = tag2.first ? prod : acc + prod;

  always_comb begin
    case (mode)
      MODE_SET: res = acc_next;
      MODE_ADD: res = cur + acc_next;
      MODE_SUB: res = cur - acc_next;
      MODE_NEG: res = 16'd0 - acc_next;
      default:  res = acc_next;
    endcase
  end

  always_ff @(posedge clk) begin
    if (tag2.valid) acc <= acc_next;
  end

  always_comb begin
    wb.en   = tag2.valid && tag2.last_k;
    wb.addr = cell_addr(tag2.i, tag2.j);
    wb.data = res;
  end

  always_ff @(posedge clk) begin
    if (rst) res_valid <= 1'b0;
    else     res_valid <= wb.en;
    res_item.out_row <= 3'(tag2.i);
    res_item.out_col <= 3'(tag2.j);
    res_item.result  <= res;
    res_item.last    <= tag2.last_elem;
  end

endmodule

@@ sv/int16_matrix_multiply.sv @@
// ----------------------------------------------------------------------------
// int16_matrix_multiply
// 16-bit signed matrix multiply over stored a, b and c with wrap to 16 bits
// ----------------------------------------------------------------------------
// a load item (kind load a, load b or load c) is taken and busy
// stays low, so loads stream at one item per cycle. a start item holds busy
// high until its last element is written back: one multiply-accumulate unit is fed
// one a/b pair per cycle from the store read ports, and the read and multiply
// stages are registered behind the sequencer. the result register follows,
// so the final element shows in the first cycle with busy low. each new c
// element shows on res_item for exactly one cycle with res_valid high; the
// receiver cannot stall, so it must take every element as it comes. elements
// leave in row-major order, the final one with last set. configuration writes
// are taken only while busy is low. store c clears to zero at reset through
// per-entry valid bits; a and b hold no reset value.
// ----------------------------------------------------------------------------
module int16_matrix_multiply (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  imm_pkg::in_item_t   cmd,
  output logic                res_valid,
  output imm_pkg::out_item_t  res_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [3:0]          cfg_data
);
  import imm_pkg::*;

  // configuration registers
  logic [3:0] out_rows, out_cols, inner_len;
  logic       transpose_a, transpose_b;
  logic [1:0] mode;

  // stores
  logic [15:0] store_a [CELLS];
  logic [15:0] store_b [CELLS];
  logic [15:0] store_c [CELLS];
  logic [CELLS-1:0] c_valid;

  logic              accept;
  logic              go;
  logic              load_ok;
  logic [ADDR_W-1:0] load_addr;
  logic              running;
  logic              mac_active;
  logic [ADDR_W-1:0] a_addr, b_addr, c_addr;
  imm_tag_t          tag0, tag1;
  imm_wb_t           wb;

  // read stage outputs
  logic [15:0] a_q, b_q, c_q;
  logic        cv_q;

  assign busy      = running | tag1.valid | mac_active;
  assign cfg_ready = ~busy;
  assign accept    = start & ~busy;
  assign go        = accept & (cmd.kind == KIND_START);

  // loads beyond the store size are dropped
  assign load_ok   = (int'(cmd.row) < MAX_DIM) && (int'(cmd.col) < MAX_DIM);
  assign load_addr = cell_addr(DIM_W'(cmd.row), DIM_W'(cmd.col));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_rows    <= 4'd8;
      out_cols    <= 4'd8;
      inner_len   <= 4'd8;
      transpose_a <= 1'b0;
      transpose_b <= 1'b0;
      mode        <= MODE_SET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_OUT_ROWS:    out_rows    <= cfg_data;
        REG_OUT_COLS:    out_cols    <= cfg_data;
        REG_INNER_LEN:   inner_len   <= cfg_data;
        REG_TRANSPOSE_A: transpose_a <= cfg_data[0];
        REG_TRANSPOSE_B: transpose_b <= cfg_data[0];
        REG_MODE:        mode        <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  imm_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .go          (go),
    .out_rows    (out_rows),
    .out_cols    (out_cols),
    .inner_len   (inner_len),
    .transpose_a (transpose_a),
    .transpose_b (transpose_b),
    .running     (running),
    .a_addr      (a_addr),
    .b_addr      (b_addr),
    .c_addr      (c_addr),
    .tag         (tag0)
  );

  // store a: written by loads, read by the sequencer
  always_ff @(posedge clk) begin
    if (accept && load_ok && cmd.kind == KIND_LOAD_A) store_a[load_addr] <= cmd.value;
    a_q <= store_a[a_addr];
  end

  // store b
  always_ff @(posedge clk) begin
    if (accept && load_ok && cmd.kind == KIND_LOAD_B) store_b[load_addr] <= cmd.value;
    b_q <= store_b[b_addr];
  end

  // store c: loads when idle, finished elements while a product runs
  always_ff @(posedge clk) begin
    if (accept && load_ok && cmd.kind == KIND_LOAD_C) store_c[load_addr] <= cmd.value;
    else if (wb.en) store_c[wb.addr] <= wb.data;
    c_q <= store_c[c_addr];
  end

  // an entry never written since reset reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= '0;
    end else begin
      if (accept && load_ok && cmd.kind == KIND_LOAD_C) c_valid[load_addr] <= 1'b1;
      else if (wb.en) c_valid[wb.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    cv_q <= c_valid[c_addr];
  end

  // tag follows the read stage
  always_ff @(posedge clk) begin
    if (rst) tag1.valid <= 1'b0;
    else     tag1.valid <= tag0.valid;
    tag1.first     <= tag0.first;
    tag1.last_k    <= tag0.last_k;
    tag1.last_elem <= tag0.last_elem;
    tag1.i         <= tag0.i;
    tag1.j         <= tag0.j;
  end

  imm_mac u_mac (
    .clk       (clk),
    .rst       (rst),
    .tag_in    (tag1),
    .a_val     (a_q),
    .b_val     (b_q),
    .c_cur     (cv_q ? c_q : 16'd0),
    .mode      (mode),
    .active    (mac_active),
    .wb        (wb),
    .res_valid (res_valid),
    .res_item  (res_item)
  );

endmodule

@@ tb/imm_tb_pkg.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// imm_tb_pkg
// register indexes and the result tracker for the int16 matrix multiply bench
// ----------------------------------------------------------------------------
package imm_tb_pkg;

  import imm_pkg::*;

  // indexes with no register behind them
  localparam logic [2:0] REG_SPARE_LO    = 3'd6;
  localparam logic [2:0] REG_SPARE_HI    = 3'd7;

  // mirrors stores a, b, c and the registers; keeps the c elements still owed
  class gemm_board;
    logic [15:0] mat_a [CELLS];
    logic [15:0] mat_b [CELLS];
    logic [15:0] mat_c [CELLS];
    logic [3:0]  dim_rows;
    logic [3:0]  dim_cols;
    logic [3:0]  dim_inner;
    bit          flip_a;
    bit          flip_b;
    logic [1:0]  c_mode;
    out_item_t   c_elems_due [$];
    int          failures;
    int          products;
    int          elems_checked;

    function new();
      foreach (mat_c[n]) begin
        mat_a[n] = '0;
        mat_b[n] = '0;
        mat_c[n] = '0;
      end
      dim_rows  = 4'd8;
      dim_cols  = 4'd8;
      dim_inner = 4'd8;
      flip_a    = 1'b0;
      flip_b    = 1'b0;
      c_mode    = MODE_SET;
      failures  = 0;
      products  = 0;
      elems_checked = 0;
    endfunction

    function int pending();
      return c_elems_due.size();
    endfunction

    // sizes saturate to 1..MAX_DIM when a product starts
    function int fit_dim(logic [3:0] v);
      if (v == 4'd0) return 1;
      if (int'(v) > MAX_DIM) return MAX_DIM;
      return int'(v);
    endfunction

    function void set_register(logic [2:0] idx, logic [3:0] data);
      case (idx)
        REG_OUT_ROWS:    dim_rows  = data;
        REG_OUT_COLS:    dim_cols  = data;
        REG_INNER_LEN:   dim_inner = data;
        REG_TRANSPOSE_A: flip_a    = data[0];
        REG_TRANSPOSE_B: flip_b    = data[0];
        REG_MODE:        c_mode    = data[1:0];
        default: ;
      endcase
    endfunction

    function void note_failure(string msg);
      failures++;
      $display("%0t: %s", $time, msg);
    endfunction

    // new c = P, c + P, c - P or -P, everything wrapping at 16 bits
    function void multiply_into_c();
      int          rows, cols, inner;
      logic [15:0] acc, av, bv, fresh, cur;
      logic signed [31:0] prod;
      out_item_t   e;
      rows  = fit_dim(dim_rows);
      cols  = fit_dim(dim_cols);
      inner = fit_dim(dim_inner);
      products++;
      for (int i = 0; i < rows; i++) begin
        for (int j = 0; j < cols; j++) begin
          acc = '0;
          for (int k = 0; k < inner; k++) begin
            av   = flip_a ? mat_a[k * MAX_DIM + i] : mat_a[i * MAX_DIM + k];
            bv   = flip_b ? mat_b[j * MAX_DIM + k] : mat_b[k * MAX_DIM + j];
            prod = $signed(av) * $signed(bv);
            acc  = acc + prod[15:0];
          end
          cur = mat_c[i * MAX_DIM + j];
          case (c_mode)
            MODE_SET: fresh = acc;
            MODE_ADD: fresh = cur + acc;
            MODE_SUB: fresh = cur - acc;
            default:  fresh = 16'd0 - acc;
          endcase
          mat_c[i * MAX_DIM + j] = fresh;
          e.out_row = 3'(i);
          e.out_col = 3'(j);
          e.result  = fresh;
          e.last    = (i == rows - 1) && (j == cols - 1);
          c_elems_due.push_back(e);
        end
      end
    endfunction

    function void take_item(in_item_t it);
      case (it.kind)
        KIND_LOAD_A: mat_a[{it.row, it.col}] = it.value;
        KIND_LOAD_B: mat_b[{it.row, it.col}] = it.value;
        KIND_LOAD_C: mat_c[{it.row, it.col}] = it.value;
        default:     multiply_into_c();
      endcase
    endfunction

    function void match_elem(out_item_t got);
      out_item_t want;
      if (c_elems_due.size() == 0) begin
        note_failure($sformatf("element (%0d,%0d) = %0d arrived with nothing expected",
                               got.out_row, got.out_col, got.result));
        return;
      end
      want = c_elems_due.pop_front();
      elems_checked++;
      if (got.out_row !== want.out_row)
        note_failure($sformatf("out_row mismatch: expected %0d, actual %0d",
                               want.out_row, got.out_row));
      if (got.out_col !== want.out_col)
        note_failure($sformatf("out_col mismatch: expected %0d, actual %0d",
                               want.out_col, got.out_col));
      if (got.result !== want.result)
        note_failure($sformatf("result mismatch at (%0d,%0d): expected %0d, actual %0d",
                               want.out_row, want.out_col, want.result, got.result));
      if (got.last !== want.last)
        note_failure($sformatf("last mismatch at (%0d,%0d): expected %0b, actual %0b",
                               want.out_row, want.out_col, want.last, got.last));
    endfunction
  endclass

endpackage

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for int16_matrix_multiply
// ----------------------------------------------------------------------------
// loads a, b and c element by element, starts products under many register
// settings and checks every emitted c element, in order, against a tracker
// that keeps its own copy of the three stores. a short directed part hits the
// value extremes, each mode, both transposes and saturating sizes; random
// phases follow, each one a fresh register setting, loads and products.
// ----------------------------------------------------------------------------
module tb;

  import imm_pkg::*;
  import imm_tb_pkg::*;

  localparam int ITEM_TARGET   = 170;
  localparam int SETTLE_CYCLES = 6;     // margin after the last element; busy is already low by then
  localparam int TAIL_CYCLES   = 24;
  localparam int QUIET_LIMIT   = 4000;  // well above the busy time of a full 8x8x8 product

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      start     = 1'b0;
  logic      busy;
  in_item_t  cmd       = '0;
  logic      res_valid;
  out_item_t res_item;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [3:0] cfg_data  = '0;

  gemm_board board;

  // operand cells already written; a product must never read an unwritten one
  bit a_loaded [CELLS];
  bit b_loaded [CELLS];

  bit steady;          // phase with no gaps between items
  int items_sent;
  int setups;
  int quiet;

  int16_matrix_multiply i_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_item  (res_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // results cannot be held off: take every strobed element
  always @(posedge clk) begin
    if (!rst && res_valid) board.match_elem(res_item);
  end

  // watchdog: anything accepted on any port restarts the count
  always @(posedge clk) begin
    if (rst || (start && !busy) || res_valid || (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= QUIET_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // biased toward the 16-bit extremes and tiny values
  function automatic logic [15:0] random_value();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($urandom_range(0, 8) - 4);
      default: return 16'($urandom);
    endcase
  endfunction

  // mostly small sizes, now and then the largest or an out-of-range value
  function automatic logic [3:0] pick_dim();
    int r;
    r = $urandom_range(0, 23);
    if (r < 16) return 4'($urandom_range(1, 3));
    if (r < 20) return 4'($urandom_range(4, 7));
    if (r == 20) return 4'd0;
    if (r == 21) return 4'd8;
    return 4'($urandom_range(9, 15));
  endfunction

  // start stays high from one item to the next when there is no gap
  task automatic send_item(input in_item_t it);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 17);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    cmd   <= it;
    do @(posedge clk); while (busy);
    board.take_item(it);
    items_sent++;
    if (it.kind == KIND_LOAD_A) a_loaded[{it.row, it.col}] = 1'b1;
    if (it.kind == KIND_LOAD_B) b_loaded[{it.row, it.col}] = 1'b1;
  endtask

  task automatic send_load(input logic [1:0] kind, input int r, input int c,
                           input logic [15:0] v);
    in_item_t it;
    it.kind  = kind;
    it.row   = 3'(r);
    it.col   = 3'(c);
    it.value = v;
    send_item(it);
  endtask

  // row, col and value mean nothing on a start item, so they get noise
  task automatic send_start();
    in_item_t it;
    it.kind  = KIND_START;
    it.row   = 3'($urandom);
    it.col   = 3'($urandom);
    it.value = 16'($urandom);
    send_item(it);
  endtask

  // write any a/b cell the coming product reads but nobody loaded yet
  task automatic run_product();
    int rows, cols, inner, slot;
    rows  = board.fit_dim(board.dim_rows);
    cols  = board.fit_dim(board.dim_cols);
    inner = board.fit_dim(board.dim_inner);
    for (int i = 0; i < rows; i++) begin
      for (int k = 0; k < inner; k++) begin
        slot = board.flip_a ? k * MAX_DIM + i : i * MAX_DIM + k;
        if (!a_loaded[slot])
          send_load(KIND_LOAD_A, slot / MAX_DIM, slot % MAX_DIM, random_value());
      end
    end
    for (int k = 0; k < inner; k++) begin
      for (int j = 0; j < cols; j++) begin
        slot = board.flip_b ? j * MAX_DIM + k : k * MAX_DIM + j;
        if (!b_loaded[slot])
          send_load(KIND_LOAD_B, slot / MAX_DIM, slot % MAX_DIM, random_value());
      end
    end
    send_start();
  endtask

  // sender holds off until every owed element is back, then lets the block settle
  task automatic settle();
    start <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // writes all six registers back to back, optionally one unmapped index too
  task automatic configure(input logic [3:0] rows, input logic [3:0] cols,
                           input logic [3:0] inner, input logic [3:0] ta,
                           input logic [3:0] tb_flip, input logic [3:0] mode_v,
                           input bit spare);
    logic [REG_MODE:0][3:0] vals;
    logic [2:0] idx;
    logic [3:0] junk;
    vals[REG_OUT_ROWS]    = rows;
    vals[REG_OUT_COLS]    = cols;
    vals[REG_INNER_LEN]   = inner;
    vals[REG_TRANSPOSE_A] = ta;
    vals[REG_TRANSPOSE_B] = tb_flip;
    vals[REG_MODE]        = mode_v;
    for (int r = REG_OUT_ROWS; r <= REG_MODE; r++) begin
      cfg_valid <= 1'b1;
      cfg_index <= 3'(r);
      cfg_data  <= vals[r];
      do @(posedge clk); while (!cfg_ready);
      board.set_register(3'(r), vals[r]);
    end
    if (spare) begin
      // nothing lives at these indexes; the write must change nothing
      idx  = $urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO;
      junk = 4'($urandom);
      cfg_valid <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= junk;
      do @(posedge clk); while (!cfg_ready);
      board.set_register(idx, junk);
    end
    cfg_valid <= 1'b0;
    setups++;
  endtask

  // one random phase: new setting, loads mixed with products, then a drain
  task automatic random_phase();
    in_item_t it;
    int steps;
    configure(pick_dim(), pick_dim(), pick_dim(), 4'($urandom), 4'($urandom),
              4'($urandom), $urandom_range(0, 7) == 0);
    steady = ($urandom_range(0, 3) == 0);
    steps  = $urandom_range(2, 10);
    repeat (steps) begin
      if ($urandom_range(0, 2) == 0) begin
        run_product();
      end else begin
        it.kind  = 2'($urandom_range(KIND_LOAD_A, KIND_LOAD_C));
        it.row   = 3'($urandom);
        it.col   = 3'($urandom);
        it.value = random_value();
        send_item(it);
      end
    end
    // most phases close with a product; the rest end on bare loads
    if ($urandom_range(0, 4) != 0) run_product();
    settle();
  endtask

  initial begin
    board      = new();
    steady     = 1'b0;
    items_sent = 0;
    setups     = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // 1x1x1 with both operands at the negative extreme: 2^30 wraps to zero
    configure(4'd1, 4'd1, 4'd1, 4'd0, 4'd0, 4'(MODE_SET), 1'b0);
    send_load(KIND_LOAD_A, 0, 0, 16'h8000);
    send_load(KIND_LOAD_B, 0, 0, 16'h8000);
    send_start();
    settle();

    // add onto the largest positive c so the sum wraps past the top
    configure(4'd1, 4'd1, 4'd1, 4'd0, 4'd0, 4'(MODE_ADD), 1'b1);
    send_load(KIND_LOAD_C, 0, 0, 16'h7fff);
    send_load(KIND_LOAD_A, 0, 0, 16'h7fff);
    send_load(KIND_LOAD_B, 0, 0, 16'h0001);
    send_start();
    settle();

    // 2x2x2 with both operands transposed, subtract mode, far-corner loads
    configure(4'd2, 4'd2, 4'd2, 4'd1, 4'd1, 4'(MODE_SUB), 1'b0);
    send_load(KIND_LOAD_A, 0, 1, 16'hffff);
    send_load(KIND_LOAD_A, 1, 0, 16'd12345);
    send_load(KIND_LOAD_A, 1, 1, 16'h7fff);
    send_load(KIND_LOAD_B, 0, 1, 16'h8000);
    send_load(KIND_LOAD_B, 1, 0, 16'd7);
    send_load(KIND_LOAD_B, 1, 1, 16'hfffe);
    send_load(KIND_LOAD_A, 7, 7, 16'h8000);
    send_load(KIND_LOAD_C, 7, 7, 16'h7fff);
    send_load(KIND_LOAD_B, 7, 0, 16'hffff);
    send_start();
    settle();

    // sizes out of range saturate: 15 gives 8 rows, 0 gives one column and k
    configure(4'd15, 4'd0, 4'd0, 4'd0, 4'd0, 4'(MODE_NEG), 1'b1);
    run_product();
    settle();

    while (items_sent < ITEM_TARGET) random_phase();

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("run covered %0d items over %0d register settings", items_sent, setups);
    $display("%0d products started, %0d result elements checked",
             board.products, board.elems_checked);
    if (board.failures == 0 && board.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/imm_pkg.sv
sv/imm_seq.sv
sv/imm_mac.sv
sv/int16_matrix_multiply.sv
tb/imm_tb_pkg.sv
tb/tb.sv
